/* design/tile_map_rect_collision_assert.svh */
// ----------------------------------------------------------------------------
// tile_map_rect_collision assertion macros
// Clocked assertion helpers shared by the tile map collision block.
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_RECT_COLLISION_ASSERT_SVH
`define TILE_MAP_RECT_COLLISION_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_IMPL(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);

`else

`define ASSERT_IMPL(lbl, ck, rn, prop, msg)
`define ASSERT_NEVER(lbl, ck, rn, cond, msg)

`endif

`endif

/* design/tmrc_pkg.sv */
// ----------------------------------------------------------------------------
// tmrc_pkg
// Shared constants, codes, types and helpers of the tile map collision block.
// ----------------------------------------------------------------------------
package tmrc_pkg;

    // Map store geometry
    localparam int MAP_COLS    = 64;
    localparam int MAP_ROWS    = 64;
    localparam int TILE_SHIFT  = 5;
    localparam int TILE_PIXELS = 1 << TILE_SHIFT;

    localparam int COL_W  = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int ROW_W  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int DEPTH  = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W  = $clog2(((MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS) + 1);

    // Signed pixel math: 16-bit edge plus 12-bit extent, map edge up to 2048
    localparam int PIX_W = 18;

    // Field widths
    localparam int CFG_W  = 7;
    localparam int CODE_W = 5;
    localparam int REG_W  = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CODE_W-1:0] SOLID_CODE = CODE_W'(8);

    // Register indexes (byte address bit 2)
    typedef enum logic {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } tmrc_reg_t;

    // Request operation codes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } tmrc_op_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } tmrc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic tile_write;
        logic query_load;
        logic scan_issue;
        logic out_load;
    } tmrc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic q_empty;
        logic hit_now;
        logic last_issue;
        logic out_full;
    } tmrc_sts_t;

    // Linear tile store address of a row and column
    function automatic logic [ADDR_W-1:0] tile_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * MAP_COLS + int'(col));
    endfunction

endpackage

/* design/tmrc_req_if.sv */
// ----------------------------------------------------------------------------
// tmrc_req_if
// Request channel: tile writes and rectangle queries with valid/ready.
// ----------------------------------------------------------------------------
interface tmrc_req_if;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [5:0]         tile_col;
    logic [5:0]         tile_row;
    logic [4:0]         tile_code;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;

    modport source (
        output valid, operation, tile_col, tile_row, tile_code,
               rect_left, rect_top, rect_width, rect_height,
        input  ready
    );

    modport sink (
        input  valid, operation, tile_col, tile_row, tile_code,
               rect_left, rect_top, rect_width, rect_height,
        output ready
    );

endinterface

/* design/tmrc_rsp_if.sv */
// ----------------------------------------------------------------------------
// tmrc_rsp_if
// Response channel: one hit flag per query with valid/ready.
// ----------------------------------------------------------------------------
interface tmrc_rsp_if;

    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );

endinterface

/* design/tmrc_regs.sv */
// ----------------------------------------------------------------------------
// tmrc_regs
// APB register file holding the map width and height in tiles.
// ----------------------------------------------------------------------------
module tmrc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tmrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tmrc_pkg::REG_W-1:0]      pwdata,
    output logic [tmrc_pkg::REG_W-1:0]      prdata,
    output logic                           pready,
    output logic [tmrc_pkg::CFG_W-1:0]      map_width,
    output logic [tmrc_pkg::CFG_W-1:0]      map_height
);
    import tmrc_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    tmrc_reg_t        reg_sel;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_sel = tmrc_reg_t'(paddr[APB_ADDR_W-1]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Take register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MAP_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_MAP_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:        width_reg  <= width_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_sel)
            REG_MAP_WIDTH:  prdata = REG_W'(width_reg);
            REG_MAP_HEIGHT: prdata = REG_W'(height_reg);
            default:        prdata = '0;
        endcase
    end

    assign map_width  = width_reg;
    assign map_height = height_reg;

endmodule

/* design/tmrc_dp.sv */
// ----------------------------------------------------------------------------
// tmrc_dp
// Datapath: tile store, rectangle clipping, tile scan counters and result register.
// ----------------------------------------------------------------------------
`include "tile_map_rect_collision_assert.svh"

module tmrc_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tmrc_pkg::tmrc_cmd_t        cmd,
    output tmrc_pkg::tmrc_sts_t        sts,
    input  logic [tmrc_pkg::CFG_W-1:0] map_width,
    input  logic [tmrc_pkg::CFG_W-1:0] map_height,
    input  logic [5:0]                tile_col,
    input  logic [5:0]                tile_row,
    input  logic [4:0]                tile_code,
    input  logic signed [15:0]        rect_left,
    input  logic signed [15:0]        rect_top,
    input  logic [11:0]               rect_width,
    input  logic [11:0]               rect_height,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_hit
);
    import tmrc_pkg::*;

    // Tile store
    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CODE_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_in_map;

    // Clearing sweep
    logic [ADDR_W-1:0] clr_reg;

    // Clipping
    logic [DIM_W-1:0]        wt_sat;
    logic [DIM_W-1:0]        ht_sat;
    logic signed [PIX_W-1:0] map_r;
    logic signed [PIX_W-1:0] map_b;
    logic signed [PIX_W-1:0] left_s;
    logic signed [PIX_W-1:0] top_s;
    logic signed [PIX_W-1:0] right_s;
    logic signed [PIX_W-1:0] bottom_s;
    logic signed [PIX_W-1:0] lc;
    logic signed [PIX_W-1:0] tc;
    logic signed [PIX_W-1:0] rc;
    logic signed [PIX_W-1:0] bc;
    logic signed [PIX_W-1:0] rc_m1;
    logic signed [PIX_W-1:0] bc_m1;
    logic                    empty;

    // Scan
    logic [COL_W-1:0] sx_reg;
    logic [COL_W-1:0] ex_reg;
    logic [ROW_W-1:0] ey_reg;
    logic [COL_W-1:0] x_reg;
    logic [ROW_W-1:0] y_reg;
    logic             empty_reg;
    logic             hit_reg;
    logic             last_issue;
    logic             solid;

    // Result
    logic out_valid_reg;
    logic out_hit_reg;

    // Clamp map size to the store and scale to pixels
    always_comb
    begin
        wt_sat = (int'(map_width)  > MAP_COLS) ? DIM_W'(MAP_COLS) : DIM_W'(map_width);
        ht_sat = (int'(map_height) > MAP_ROWS) ? DIM_W'(MAP_ROWS) : DIM_W'(map_height);
        map_r  = PIX_W'(int'(wt_sat) * TILE_PIXELS);
        map_b  = PIX_W'(int'(ht_sat) * TILE_PIXELS);
    end

    // Clip the query rectangle to the map
    always_comb
    begin
        left_s   = PIX_W'(rect_left);
        top_s    = PIX_W'(rect_top);
        right_s  = left_s + $signed(PIX_W'(rect_width));
        bottom_s = top_s + $signed(PIX_W'(rect_height));
        lc       = (left_s < 0) ? '0 : left_s;
        tc       = (top_s < 0) ? '0 : top_s;
        rc       = (right_s > map_r) ? map_r : right_s;
        bc       = (bottom_s > map_b) ? map_b : bottom_s;
        rc_m1    = rc - $signed(PIX_W'(1));
        bc_m1    = bc - $signed(PIX_W'(1));
        empty    = !((rc > lc) && (bc > tc));
    end

    // Latch tile ranges on query accept, then walk row by row
    assign last_issue = (x_reg == ex_reg) && (y_reg == ey_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.query_load)
        begin
            sx_reg <= lc[TILE_SHIFT +: COL_W];
            ex_reg <= rc_m1[TILE_SHIFT +: COL_W];
            ey_reg <= bc_m1[TILE_SHIFT +: ROW_W];
            x_reg  <= lc[TILE_SHIFT +: COL_W];
            y_reg  <= tc[TILE_SHIFT +: ROW_W];
        end
        else if (cmd.scan_issue)
        begin
            if (x_reg == ex_reg)
            begin
                x_reg <= sx_reg;
                y_reg <= y_reg + ROW_W'(1);
            end
            else
            begin
                x_reg <= x_reg + COL_W'(1);
            end
        end
    end

    // Query control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg    <= 1'b1;
            hit_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            clr_reg      <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_issue;
            if (cmd.query_load)
            begin
                empty_reg <= empty;
                hit_reg   <= 1'b0;
            end
            else if (rd_valid_reg && solid)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
        end
    end

    // Write port: clearing sweep or tile write
    always_comb
    begin
        wr_in_map = (int'(tile_col) < MAP_COLS) && (int'(tile_row) < MAP_ROWS);
        wr_en     = cmd.clear_step || (cmd.tile_write && wr_in_map);
        wr_addr   = cmd.clear_step ? clr_reg
                                   : tile_addr(ROW_W'(tile_row), COL_W'(tile_col));
        wr_data   = cmd.clear_step ? '0 : tile_code;
        rd_addr   = tile_addr(y_reg, x_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign solid = (rd_data_reg >= SOLID_CODE);

    // Result register: load on finish, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_hit_reg <= hit_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;

    // Status to the controller
    always_comb
    begin
        sts.clear_last = (clr_reg == ADDR_W'(DEPTH - 1));
        sts.q_empty    = empty_reg;
        sts.hit_now    = rd_valid_reg && solid;
        sts.last_issue = last_issue;
        sts.out_full   = out_valid_reg;
    end

    `ASSERT_IMPL(a_scan_in_range, clk, rst_n, cmd.scan_issue |-> ((x_reg <= ex_reg) && (y_reg <= ey_reg)), "tile scan left the clipped range")
    `ASSERT_NEVER(a_scan_empty, clk, rst_n, cmd.scan_issue && empty_reg, "tile read issued for an empty rectangle")

endmodule

/* design/tmrc_ctrl.sv */
// ----------------------------------------------------------------------------
// tmrc_ctrl
// Controller: store clearing after reset, request accept, tile scan and result hand-off.
// ----------------------------------------------------------------------------
`include "tile_map_rect_collision_assert.svh"

module tmrc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_op,
    output logic                in_ready,
    input  logic                out_ready,
    output tmrc_pkg::tmrc_cmd_t cmd,
    input  tmrc_pkg::tmrc_sts_t sts
);
    import tmrc_pkg::*;

    tmrc_state_t state_reg;
    tmrc_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_QUERY)
                    begin
                        cmd.query_load = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.tile_write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                priority if (sts.q_empty)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.hit_now)
                begin
                    cmd.scan_issue = 1'b1;
                    state_next     = ST_FINISH;
                end
                else if (sts.last_issue)
                begin
                    cmd.scan_issue = 1'b1;
                    state_next     = ST_DRAIN;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Hold until the result register is free
                if (!sts.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_no_overwrite, clk, rst_n, (cmd.out_load && sts.out_full) |-> out_ready, "pending result overwritten")
    `ASSERT_IMPL(a_query_scans, clk, rst_n, (in_valid && in_ready && (in_op == OP_QUERY)) |=> (state_reg == ST_SCAN), "query accepted without scan")
    `ASSERT_IMPL(a_clear_done, clk, rst_n, ((state_reg == ST_CLEAR) && sts.clear_last) |=> (state_reg == ST_IDLE), "clearing sweep did not finish")

endmodule

/* design/tile_map_rect_collision.sv */
// ----------------------------------------------------------------------------
// tile_map_rect_collision
// Tile map store with pixel rectangle collision queries.
// ----------------------------------------------------------------------------
// After reset the block clears its MAP_ROWS x MAP_COLS tile store (4096 entries), one
// entry per cycle, so the request channel stays not ready until the sweep ends; register
// writes are taken throughout. A tile write is done in the cycle of its transfer. A
// query is scanned in ST_SCAN, which reads tiles up to and including the first solid
// one (or all tiles under the clipped rectangle when none is solid); it then goes through
// ST_DRAIN when no tile hit, to ST_FINISH, which loads the result, and back to ST_IDLE
// for the next request. An empty clipped rectangle goes from ST_SCAN to ST_FINISH. The tile
// store has a single read port, so the scan reads one tile per cycle. The result sits in an
// output register, so the next request is taken while it waits to transfer.
// ----------------------------------------------------------------------------
module tile_map_rect_collision (
    input  logic                            clk,
    input  logic                            rst_n,
    tmrc_req_if.sink                        request,
    tmrc_rsp_if.source                      response,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tmrc_pkg::REG_W-1:0]      pwdata,
    output logic [tmrc_pkg::REG_W-1:0]      prdata,
    output logic                            pready
);
    import tmrc_pkg::*;

    tmrc_cmd_t        cmd;
    tmrc_sts_t        sts;
    logic [CFG_W-1:0] map_width;
    logic [CFG_W-1:0] map_height;
    logic             req_ready;
    logic             rsp_valid;
    logic             rsp_hit;

    // Configuration registers
    tmrc_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .map_width  (map_width),
        .map_height (map_height)
    );

    // Controller
    tmrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_op     (request.operation),
        .in_ready  (req_ready),
        .out_ready (response.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath
    tmrc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .map_width   (map_width),
        .map_height  (map_height),
        .tile_col    (request.tile_col),
        .tile_row    (request.tile_row),
        .tile_code   (request.tile_code),
        .rect_left   (request.rect_left),
        .rect_top    (request.rect_top),
        .rect_width  (request.rect_width),
        .rect_height (request.rect_height),
        .out_valid   (rsp_valid),
        .out_ready   (response.ready),
        .out_hit     (rsp_hit)
    );

    assign request.ready  = req_ready;
    assign response.valid = rsp_valid;
    assign response.hit   = rsp_hit;

endmodule
